// ===== sv/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, register indexes and helpers for the compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

   localparam logic [1:0] CSR_TEMP_CAL  = 2'd0;
   localparam logic [1:0] CSR_PRESS_LOW = 2'd1;
   localparam logic [1:0] CSR_PRESS_MID = 2'd2;
   localparam logic [1:0] CSR_PRESS_HI  = 2'd3;

   localparam int unsigned DIV_STAGES = 32;

   // coefficients, already extended to 32 bits
   typedef struct packed {
      logic [31:0] t1;
      logic [31:0] t2;
      logic [31:0] t3;
      logic [31:0] p1;
      logic [31:0] p2;
      logic [31:0] p3;
      logic [31:0] p4;
      logic [31:0] p5;
      logic [31:0] p6;
      logic [31:0] p7;
      logic [31:0] p8;
      logic [31:0] p9;
   } cal_type;

   // fields that ride along with the pressure divide
   typedef struct packed {
      logic [23:0] centi;
      logic [31:0] fine;
      logic        pvalid;
      logic        post;
   } side_type;

   function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] x);
      return {{16{x[15]}}, x};
   endfunction

endpackage

`default_nettype wire

// ===== sv/ptc_front.sv =====
// ----------------------------------------------------------------------------
// ptc_front
// Temperature compensation and pressure numerator/denominator, eleven stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_front
   import ptc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  wire logic [19:0] raw_t,
   input  wire logic [19:0] raw_p,
   input  wire cal_type     cal,
   output logic             out_valid,
   output logic [31:0]      out_dividend,
   output logic [31:0]      out_divisor,
   output side_type         out_side
);

   logic [10:0] vld_ff, vld_in;

   logic [31:0] x1_ff, d1_ff;
   logic [19:0] adcp1_ff, adcp2_ff, adcp3_ff, adcp4_ff, adcp5_ff, adcp6_ff,
                adcp7_ff, adcp8_ff;
   logic [31:0] m2_ff, dd2_ff;
   logic [31:0] at3_ff, e3_ff;
   logic [31:0] fine4_ff, fine5_ff, fine6_ff, fine7_ff, fine8_ff, fine9_ff,
                fine10_ff;
   logic [23:0] centi5_ff, centi6_ff, centi7_ff, centi8_ff, centi9_ff, centi10_ff;
   logic [31:0] a5_ff, q5_ff;
   logic [31:0] qq6_ff, ap6_ff, p2a6_ff;
   logic [31:0] b7_ff, c7_ff, ap7_ff, p2a7_ff;
   logic [31:0] b8_ff, a8_ff;
   logic [31:0] a9_ff, pn9_ff;
   logic [31:0] den10_ff, pm10_ff;
   logic [31:0] dvd_ff, dvs_ff;
   side_type    side_ff;

   logic [31:0] x1_in, d1_in, a5_in, f5x, b8_in, a8_in;

   assign vld_in = {vld_ff[9:0], in_valid};

   always_comb begin
      x1_in = 32'(raw_t >> 3) - {cal.t1[30:0], 1'b0};
      d1_in = 32'(raw_t >> 4) - cal.t1;
      a5_in = asr32(fine4_ff, 1) - 32'd64000;
      f5x   = {fine4_ff[29:0], 2'b00} + fine4_ff + 32'd128;
      b8_in = asr32(b7_ff + {ap7_ff[30:0], 1'b0}, 2) + {cal.p4[15:0], 16'h0000};
      a8_in = asr32(asr32(c7_ff, 3) + asr32(p2a7_ff, 1), 18);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1
         x1_ff    <= x1_in;
         d1_ff    <= d1_in;
         adcp1_ff <= raw_p;
         // stage 2
         m2_ff    <= 32'(x1_ff * cal.t2);
         dd2_ff   <= 32'(d1_ff * d1_ff);
         adcp2_ff <= adcp1_ff;
         // stage 3
         at3_ff   <= asr32(m2_ff, 11);
         e3_ff    <= 32'(asr32(dd2_ff, 12) * cal.t3);
         adcp3_ff <= adcp2_ff;
         // stage 4
         fine4_ff <= at3_ff + asr32(e3_ff, 14);
         adcp4_ff <= adcp3_ff;
         // stage 5: low 24 bits of the arithmetic shift by 8
         a5_ff     <= a5_in;
         q5_ff     <= asr32(a5_in, 2);
         centi5_ff <= f5x[31:8];
         fine5_ff  <= fine4_ff;
         adcp5_ff  <= adcp4_ff;
         // stage 6
         qq6_ff    <= 32'(q5_ff * q5_ff);
         ap6_ff    <= 32'(a5_ff * cal.p5);
         p2a6_ff   <= 32'(cal.p2 * a5_ff);
         centi6_ff <= centi5_ff;
         fine6_ff  <= fine5_ff;
         adcp6_ff  <= adcp5_ff;
         // stage 7
         b7_ff     <= 32'(asr32(qq6_ff, 11) * cal.p6);
         c7_ff     <= 32'(cal.p3 * asr32(qq6_ff, 13));
         ap7_ff    <= ap6_ff;
         p2a7_ff   <= p2a6_ff;
         centi7_ff <= centi6_ff;
         fine7_ff  <= fine6_ff;
         adcp7_ff  <= adcp6_ff;
         // stage 8
         b8_ff     <= b8_in;
         a8_ff     <= a8_in;
         centi8_ff <= centi7_ff;
         fine8_ff  <= fine7_ff;
         adcp8_ff  <= adcp7_ff;
         // stage 9
         a9_ff     <= 32'((32'd32768 + a8_ff) * cal.p1);
         pn9_ff    <= (32'd1048576 - 32'(adcp8_ff)) - asr32(b8_ff, 12);
         centi9_ff <= centi8_ff;
         fine9_ff  <= fine8_ff;
         // stage 10
         den10_ff   <= asr32(a9_ff, 15);
         pm10_ff    <= 32'(pn9_ff * 32'd3125);
         centi10_ff <= centi9_ff;
         fine10_ff  <= fine9_ff;
         // stage 11: pick divide form by the top bit of the numerator
         dvd_ff         <= pm10_ff[31] ? pm10_ff : {pm10_ff[30:0], 1'b0};
         dvs_ff         <= den10_ff;
         side_ff.post   <= pm10_ff[31];
         side_ff.pvalid <= (den10_ff != 32'd0);
         side_ff.centi  <= centi10_ff;
         side_ff.fine   <= fine10_ff;
      end
   end

   assign out_valid    = vld_ff[10];
   assign out_dividend = dvd_ff;
   assign out_divisor  = dvs_ff;
   assign out_side     = side_ff;

endmodule

`default_nettype wire

// ===== sv/ptc_div.sv =====
// ----------------------------------------------------------------------------
// ptc_div
// Unsigned 32/32 restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_div
   import ptc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  wire logic [31:0] in_dividend,
   input  wire logic [31:0] in_divisor,
   input  wire side_type    in_side,
   output logic             out_valid,
   output logic [31:0]      out_quotient,
   output side_type         out_side
);

   logic [31:0] rem_ff [DIV_STAGES];
   logic [31:0] quo_ff [DIV_STAGES];
   logic [31:0] dvs_ff [DIV_STAGES];
   side_type    side_ff[DIV_STAGES];
   logic [DIV_STAGES-1:0] vld_ff;

   logic [31:0] rem_src [DIV_STAGES];
   logic [31:0] quo_src [DIV_STAGES];
   logic [31:0] dvs_src [DIV_STAGES];
   side_type    side_src[DIV_STAGES];
   logic [31:0] rem_in  [DIV_STAGES];
   logic [31:0] quo_in  [DIV_STAGES];
   logic [32:0] trial   [DIV_STAGES];

   // quo carries the unshifted dividend bits in and the quotient bits out
   always_comb begin
      for (int i = 0; i < DIV_STAGES; i++) begin
         if (i == 0) begin
            rem_src[i]  = '0;
            quo_src[i]  = in_dividend;
            dvs_src[i]  = in_divisor;
            side_src[i] = in_side;
         end else begin
            rem_src[i]  = rem_ff[i-1];
            quo_src[i]  = quo_ff[i-1];
            dvs_src[i]  = dvs_ff[i-1];
            side_src[i] = side_ff[i-1];
         end
         trial[i] = {rem_src[i], quo_src[i][31]};
         if (trial[i] >= {1'b0, dvs_src[i]}) begin
            rem_in[i] = 32'(trial[i] - {1'b0, dvs_src[i]});
            quo_in[i] = {quo_src[i][30:0], 1'b1};
         end else begin
            rem_in[i] = trial[i][31:0];
            quo_in[i] = {quo_src[i][30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            rem_ff[i]  <= rem_in[i];
            quo_ff[i]  <= quo_in[i];
            dvs_ff[i]  <= dvs_src[i];
            side_ff[i] <= side_src[i];
         end
      end
   end

   assign out_valid    = vld_ff[DIV_STAGES-1];
   assign out_quotient = quo_ff[DIV_STAGES-1];
   assign out_side     = side_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== sv/ptc_back.sv =====
// ----------------------------------------------------------------------------
// ptc_back
// Second-order pressure correction, three stages ending in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_back
   import ptc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  wire logic [31:0] in_quotient,
   input  wire side_type    in_side,
   input  wire cal_type     cal,
   output logic             out_valid,
   output logic [23:0]      out_centi,
   output logic [31:0]      out_pressure,
   output logic             out_pvalid,
   output logic [31:0]      out_fine
);

   logic [2:0]  vld_ff;
   logic [31:0] p1_ff, pp1_ff, bb1_ff;
   logic [31:0] p2_ff, x2_ff, bb2_ff;
   logic [31:0] pres_ff;
   side_type    side1_ff, side2_ff, side3_ff;

   logic [31:0] p_in, s_in, pres_in;

   always_comb begin
      p_in    = in_side.post ? {in_quotient[30:0], 1'b0} : in_quotient;
      s_in    = asr32(x2_ff, 12) + asr32(bb2_ff, 13) + cal.p7;
      pres_in = side2_ff.pvalid ? p2_ff + asr32(s_in, 4) : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff    <= p_in;
         pp1_ff   <= 32'((p_in >> 3) * (p_in >> 3));
         bb1_ff   <= 32'((p_in >> 2) * cal.p8);
         side1_ff <= in_side;
         p2_ff    <= p1_ff;
         x2_ff    <= 32'(cal.p9 * (pp1_ff >> 13));
         bb2_ff   <= bb1_ff;
         side2_ff <= side1_ff;
         pres_ff  <= pres_in;
         side3_ff <= side2_ff;
      end
   end

   assign out_valid    = vld_ff[2];
   assign out_centi    = side3_ff.centi;
   assign out_pressure = pres_ff;
   assign out_pvalid   = side3_ff.pvalid;
   assign out_fine     = side3_ff.fine;

endmodule

`default_nettype wire

// ===== sv/pressure_temperature_compensation.sv =====
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Integer temperature and pressure compensation of raw sensor conversions.
// ----------------------------------------------------------------------------
// Usage:
//   Calibration words go in through the csr_ channel (index 0 temperature,
//   1..3 pressure); it is always ready and must be written while idle.
//   Raw temperature/pressure pairs enter on req_; each transfer yields one
//   result on rsp_ with temperature, pressure, a pressure-valid flag and the
//   fine temperature term.
//   The pipeline has 46 register stages: 11 front stages, 32 divider
//   stages (one quotient bit each) and 3 correction stages ending in the
//   output register.
//   Throughput is one item per cycle while a low rsp_ready does not hold it.
//   The whole pipeline advances together; when rsp_ready is low with a
//   result waiting, every stage holds and req_ready drops, so nothing is
//   lost or repeated. Bubbles in flight stay where they are meanwhile.
//   Reset clears all valid bits and the calibration words to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_temperature_compensation
   import ptc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [19:0]        req_raw_temperature,
   input  wire logic [19:0]        req_raw_pressure,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [23:0]      rsp_temperature_centi,
   output logic [31:0]             rsp_pressure_pa,
   output logic                    rsp_pressure_valid,
   output logic signed [31:0]      rsp_fine_temperature,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [63:0]        csr_wdata
);

   logic [47:0] tcal_ff;
   logic [63:0] pcal_lo_ff, pcal_mid_ff;
   logic [15:0] pcal_hi_ff;
   cal_type     cal;
   logic        en;

   logic        f_valid;
   logic [31:0] f_dividend, f_divisor;
   side_type    f_side;
   logic        d_valid;
   logic [31:0] d_quotient;
   side_type    d_side;
   logic [23:0] b_centi;
   logic [31:0] b_fine;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tcal_ff     <= '0;
         pcal_lo_ff  <= '0;
         pcal_mid_ff <= '0;
         pcal_hi_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TEMP_CAL:  tcal_ff     <= csr_wdata[47:0];
            CSR_PRESS_LOW: pcal_lo_ff  <= csr_wdata;
            CSR_PRESS_MID: pcal_mid_ff <= csr_wdata;
            CSR_PRESS_HI:  pcal_hi_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cal.t1 = {16'h0000, tcal_ff[15:0]};
      cal.t2 = sx16(tcal_ff[31:16]);
      cal.t3 = sx16(tcal_ff[47:32]);
      cal.p1 = {16'h0000, pcal_lo_ff[15:0]};
      cal.p2 = sx16(pcal_lo_ff[31:16]);
      cal.p3 = sx16(pcal_lo_ff[47:32]);
      cal.p4 = sx16(pcal_lo_ff[63:48]);
      cal.p5 = sx16(pcal_mid_ff[15:0]);
      cal.p6 = sx16(pcal_mid_ff[31:16]);
      cal.p7 = sx16(pcal_mid_ff[47:32]);
      cal.p8 = sx16(pcal_mid_ff[63:48]);
      cal.p9 = sx16(pcal_hi_ff);
   end

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   ptc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid),
      .raw_t        (req_raw_temperature),
      .raw_p        (req_raw_pressure),
      .cal          (cal),
      .out_valid    (f_valid),
      .out_dividend (f_dividend),
      .out_divisor  (f_divisor),
      .out_side     (f_side)
   );

   ptc_div u_div (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (f_valid),
      .in_dividend  (f_dividend),
      .in_divisor   (f_divisor),
      .in_side      (f_side),
      .out_valid    (d_valid),
      .out_quotient (d_quotient),
      .out_side     (d_side)
   );

   ptc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (d_valid),
      .in_quotient  (d_quotient),
      .in_side      (d_side),
      .cal          (cal),
      .out_valid    (rsp_valid),
      .out_centi    (b_centi),
      .out_pressure (rsp_pressure_pa),
      .out_pvalid   (rsp_pressure_valid),
      .out_fine     (b_fine)
   );

   assign rsp_temperature_centi = $signed(b_centi);
   assign rsp_fine_temperature  = $signed(b_fine);

endmodule

`default_nettype wire
